// ===== rtl/sled_pkg.sv =====
// Shared types, codes and helper functions for the quoted literal escape decoder.
package sled_pkg;

   typedef enum logic [8:0] {
      PH_IDLE   = 9'b000000001,
      PH_BODY   = 9'b000000010,
      PH_ESC    = 9'b000000100,
      PH_HEX1   = 9'b000001000,
      PH_HEX2   = 9'b000010000,
      PH_UBRACE = 9'b000100000,
      PH_UDIGIT = 9'b001000000,
      PH_OCT    = 9'b010000000,
      PH_AFTER  = 9'b100000000
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_TEXT  = 2'd1;
   localparam logic [1:0] KIND_CHAR  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
   localparam logic [2:0] ERR_NO_BRACE  = 3'd2;
   localparam logic [2:0] ERR_BAD_UDIG  = 3'd3;
   localparam logic [2:0] ERR_BAD_CODE  = 3'd4;
   localparam logic [2:0] ERR_BAD_OCTAL = 3'd5;
   localparam logic [2:0] ERR_END       = 3'd6;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [20:0] CODE_LIMIT = 21'h110000;
   localparam logic [24:0] CODE_MAX   = 25'h10ffff;

   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      phase_type   phase;
      logic        single_quote;
      logic [3:0]  first_nibble;
      logic [20:0] code_accum;
      logic        code_overflow;
      logic        digits_seen;
      logic [8:0]  octal_accum;
      logic [1:0]  octal_pos;
      logic        octal_stopped;
      logic [1:0]  byte_count;
   } state_type;

   localparam state_type ST_RESET = '{
      phase: PH_IDLE, single_quote: 1'b0, first_nibble: 4'd0, code_accum: 21'd0,
      code_overflow: 1'b0, digits_seen: 1'b0, octal_accum: 9'd0, octal_pos: 2'd0,
      octal_stopped: 1'b0, byte_count: 2'd0
   };

   typedef struct packed {
      logic [2:0]                         cnt;
      logic [MAX_RESULTS-1:0][7:0]        bytes;
      logic [1:0]                         kind;
      logic [2:0]                         code;
      logic                               replay;
   } result_type;

   // value of a hex digit, 16 when the byte is no hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [7:0] t;
      t = 8'd16;
      if (b inside {[8'h30:8'h39]}) begin
         t = b - 8'h30;
      end else if (b inside {[8'h61:8'h66]}) begin
         t = b - 8'h57;
      end else if (b inside {[8'h41:8'h46]}) begin
         t = b - 8'h37;
      end
      return t[4:0];
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b, CH_BSLASH, 8'h00};
   endfunction

endpackage

// ===== rtl/sled_core.sv =====
// Next-state and result decode for one source byte of a quoted literal.
module sled_core import sled_pkg::*; (
   input  state_type   cur,
   input  logic [7:0]  byte_in,
   input  logic        opens,
   input  logic        input_end,
   output state_type   nxt,
   output result_type  res
);

   logic [7:0]  q;
   logic [4:0]  hv;
   logic [24:0] cp_shift;
   logic [20:0] cp;
   logic        od;
   logic [8:0]  oacc;
   logic [2:0]  bc_sum;

   assign q        = cur.single_quote ? CH_SQUOTE : CH_DQUOTE;
   assign hv       = hex_val(byte_in);
   assign cp_shift = {cur.code_accum, hv[3:0]};
   assign cp       = cur.code_accum;
   assign od       = byte_in inside {[8'h30:8'h37]};

   always_comb begin
      nxt  = cur;
      res  = '0;
      oacc = cur.octal_accum;
      if (input_end) begin
         if (cur.phase == PH_AFTER) begin
            nxt.phase = PH_IDLE;
            res.cnt   = 3'd1;
            res.kind  = (cur.single_quote && cur.byte_count == 2'd1) ? KIND_CHAR : KIND_TEXT;
         end else if (cur.phase != PH_IDLE) begin
            nxt.phase = PH_IDLE;
            res.cnt   = 3'd1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_END;
         end
      end else if (opens) begin
         nxt              = ST_RESET;
         nxt.single_quote = (byte_in == CH_SQUOTE);
         nxt.phase        = PH_BODY;
      end else begin
         case (cur.phase)
            PH_BODY: begin
               if (byte_in == q) begin
                  nxt.phase = PH_AFTER;
               end else if (byte_in == CH_BSLASH) begin
                  nxt.phase = PH_ESC;
               end else begin
                  res.cnt      = 3'd1;
                  res.bytes[0] = byte_in;
               end
            end
            PH_ESC: begin
               nxt.phase    = PH_BODY;
               res.cnt      = 3'd1;
               res.bytes[0] = byte_in;
               case (byte_in)
                  8'h30: res.bytes[0] = 8'h00;
                  8'h61: res.bytes[0] = 8'h07;
                  8'h62: res.bytes[0] = 8'h08;
                  8'h74: res.bytes[0] = 8'h09;
                  8'h6e: res.bytes[0] = 8'h0a;
                  8'h76: res.bytes[0] = 8'h0b;
                  8'h66: res.bytes[0] = 8'h0c;
                  8'h72: res.bytes[0] = 8'h0d;
                  8'h78: begin
                     res       = '0;
                     nxt.phase = PH_HEX1;
                  end
                  8'h75: begin
                     res       = '0;
                     nxt.phase = PH_UBRACE;
                  end
                  8'h6f: begin
                     res               = '0;
                     nxt.phase         = PH_OCT;
                     nxt.octal_accum   = 9'd0;
                     nxt.octal_pos     = 2'd0;
                     nxt.octal_stopped = 1'b0;
                  end
                  default: res.bytes[0] = byte_in;
               endcase
            end
            PH_HEX1: begin
               if (hv[4]) begin
                  nxt.phase = PH_IDLE;
                  res.cnt   = 3'd1;
                  res.kind  = KIND_ERROR;
                  res.code  = ERR_BAD_HEX;
               end else begin
                  nxt.first_nibble = hv[3:0];
                  nxt.phase        = PH_HEX2;
               end
            end
            PH_HEX2: begin
               if (hv[4]) begin
                  nxt.phase = PH_IDLE;
                  res.cnt   = 3'd1;
                  res.kind  = KIND_ERROR;
                  res.code  = ERR_BAD_HEX;
               end else begin
                  nxt.phase    = PH_BODY;
                  res.cnt      = 3'd1;
                  res.bytes[0] = {cur.first_nibble, hv[3:0]};
               end
            end
            PH_UBRACE: begin
               if (byte_in != CH_LBRACE) begin
                  nxt.phase = PH_IDLE;
                  res.cnt   = 3'd1;
                  res.kind  = KIND_ERROR;
                  res.code  = ERR_NO_BRACE;
               end else begin
                  nxt.code_accum    = 21'd0;
                  nxt.code_overflow = 1'b0;
                  nxt.digits_seen   = 1'b0;
                  nxt.phase         = PH_UDIGIT;
               end
            end
            PH_UDIGIT: begin
               if (byte_in == CH_RBRACE) begin
                  if (!cur.digits_seen || cur.code_overflow || cp >= CODE_LIMIT) begin
                     nxt.phase = PH_IDLE;
                     res.cnt   = 3'd1;
                     res.kind  = KIND_ERROR;
                     res.code  = ERR_BAD_CODE;
                  end else begin
                     nxt.phase = PH_BODY;
                     if (cp < 21'h80) begin
                        res.cnt      = 3'd1;
                        res.bytes[0] = cp[7:0];
                     end else if (cp < 21'h800) begin
                        res.cnt      = 3'd2;
                        res.bytes[0] = {3'b110, cp[10:6]};
                        res.bytes[1] = {2'b10, cp[5:0]};
                     end else if (cp < 21'h10000) begin
                        res.cnt      = 3'd3;
                        res.bytes[0] = {4'b1110, cp[15:12]};
                        res.bytes[1] = {2'b10, cp[11:6]};
                        res.bytes[2] = {2'b10, cp[5:0]};
                     end else begin
                        res.cnt      = 3'd4;
                        res.bytes[0] = {5'b11110, cp[20:18]};
                        res.bytes[1] = {2'b10, cp[17:12]};
                        res.bytes[2] = {2'b10, cp[11:6]};
                        res.bytes[3] = {2'b10, cp[5:0]};
                     end
                  end
               end else if (hv[4]) begin
                  nxt.phase = PH_IDLE;
                  res.cnt   = 3'd1;
                  res.kind  = KIND_ERROR;
                  res.code  = ERR_BAD_UDIG;
               end else begin
                  nxt.digits_seen = 1'b1;
                  if (cp_shift > CODE_MAX) begin
                     nxt.code_overflow = 1'b1;
                  end else begin
                     nxt.code_accum = cp_shift[20:0];
                  end
               end
            end
            PH_OCT: begin
               if (cur.octal_pos == 2'd0 && !od) begin
                  nxt.phase = PH_IDLE;
                  res.cnt   = 3'd1;
                  res.kind  = KIND_ERROR;
                  res.code  = ERR_BAD_OCTAL;
               end else begin
                  if (cur.octal_pos == 2'd0) begin
                     oacc = {6'd0, byte_in[2:0]};
                  end else if (!cur.octal_stopped) begin
                     if (od) begin
                        oacc = {cur.octal_accum[5:0], byte_in[2:0]};
                     end else begin
                        nxt.octal_stopped = 1'b1;
                     end
                  end
                  nxt.octal_accum = oacc;
                  if (cur.octal_pos >= 2'd2) begin
                     if (oacc[8]) begin
                        nxt.phase = PH_IDLE;
                        res.cnt   = 3'd1;
                        res.kind  = KIND_ERROR;
                        res.code  = ERR_BAD_OCTAL;
                     end else begin
                        nxt.phase    = PH_BODY;
                        res.cnt      = 3'd1;
                        res.bytes[0] = oacc[7:0];
                     end
                  end else begin
                     nxt.octal_pos = cur.octal_pos + 2'd1;
                  end
               end
            end
            PH_AFTER: begin
               if (byte_in == q) begin
                  nxt.phase = PH_BODY;
               end else if (!is_space(byte_in)) begin
                  nxt.phase  = PH_IDLE;
                  res.cnt    = 3'd1;
                  res.kind   = (cur.single_quote && cur.byte_count == 2'd1) ?
                               KIND_CHAR : KIND_TEXT;
                  res.replay = 1'b1;
               end
            end
            default: nxt = cur;
         endcase
      end
      bc_sum = {1'b0, nxt.byte_count};
      if (res.kind == KIND_DATA) begin
         bc_sum = {1'b0, nxt.byte_count} + res.cnt;
      end
      nxt.byte_count = (bc_sum > 3'd2) ? 2'd2 : bc_sum[1:0];
   end

endmodule

// ===== rtl/sled_obuf.sv =====
// Result buffer: holds the words caused by one source byte and sends them one by one.
module sled_obuf import sled_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  res,
   output logic        free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_replay,
   output logic        rsp_last
);

   logic [2:0]                  rem_ff, rem_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic [1:0]                  kind_ff;
   logic [2:0]                  code_ff;
   logic                        replay_ff;
   logic                        take;

   assign take = (rem_ff != 3'd0) && !rsp_stall;
   assign free = (rem_ff == 3'd0) || (take && rem_ff == 3'd1);

   always_comb begin
      rem_in   = rem_ff;
      bytes_in = bytes_ff;
      if (load) begin
         rem_in   = res.cnt;
         bytes_in = res.bytes;
      end else if (take) begin
         rem_in   = rem_ff - 3'd1;
         bytes_in = bytes_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (load) begin
         kind_ff   <= res.kind;
         code_ff   <= res.code;
         replay_ff <= res.replay;
      end
   end

   assign rsp_valid      = rem_ff != 3'd0;
   assign rsp_out_byte   = bytes_ff[0];
   assign rsp_kind       = kind_ff;
   assign rsp_error_code = code_ff;
   assign rsp_replay     = replay_ff;
   assign rsp_last       = rem_ff == 3'd1;

endmodule

// ===== rtl/string_literal_escape_decoder.sv =====
// Top level of the quoted literal escape decoder.
// Usage:
//   The req channel carries one source byte per word (req_byte_in), with req_opens
//   marking the opening quote and req_input_end marking end of source. The rsp
//   channel returns decoded bytes (rsp_kind data) and one closing word per literal
//   (text, char or error with rsp_error_code); rsp_last flags the final word caused
//   by a source byte. Source bytes that cause nothing produce no rsp word.
//   A word accepted lands in the input register, is decoded and loaded into the result
//   buffer once it can take the words, and shows on rsp from then.
//   Throughput: one source byte per cycle while each causes at most one word and the
//   receiver does not stall; a \u{} escape causes up to 4 words, and the result buffer
//   drains one per cycle, so the next byte that causes a word waits behind them.
//   When the receiver stalls, the buffer holds its word; a source byte that causes
//   a word then waits in the input register and req_stall rises.
//   Reset clears the decoder to idle and empties both stages; no literal is open.
module string_literal_escape_decoder import sled_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_opens,
   input  logic        req_input_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_replay,
   output logic        rsp_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_opens_ff;
   logic       in_end_ff;
   state_type  state_ff, state_in;
   result_type res;
   logic       buf_free;
   logic       advance;
   logic       accept;

   sled_core u_core (
      .cur       (state_ff),
      .byte_in   (in_byte_ff),
      .opens     (in_opens_ff),
      .input_end (in_end_ff),
      .nxt       (state_in),
      .res       (res)
   );

   assign advance   = in_valid_ff && ((res.cnt == 3'd0) || buf_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_byte_in;
         in_opens_ff <= req_opens;
         in_end_ff   <= req_input_end;
      end
   end

   sled_obuf u_obuf (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && res.cnt != 3'd0),
      .res            (res),
      .free           (buf_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_replay     (rsp_replay),
      .rsp_last       (rsp_last)
   );

endmodule
